>>> rtl/fpsa_pkg.sv
// Shared types and constants of the free page stack allocator.
package fpsa_pkg;

  // Widths of the request and result fields.
  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;

  // Command codes carried by a request.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> rtl/fpsa_if.sv
// Request and result channel interfaces of the free page stack allocator.
interface fpsa_in_if;
  import fpsa_pkg::*;

  logic  valid;
  logic  ready;
  logic  command;
  page_t freed_page;
  page_t limit_page;

  modport source (output valid, output command, output freed_page, output limit_page,
                  input ready);
  modport sink   (input valid, input command, input freed_page, input limit_page,
                  output ready);
endinterface

interface fpsa_out_if;
  import fpsa_pkg::*;

  logic   valid;
  logic   ready;
  page_t  granted_page;
  logic   granted;
  count_t free_count;

  modport source (output valid, output granted_page, output granted, output free_count,
                  input ready);
  modport sink   (input valid, input granted_page, input granted, input free_count,
                  output ready);
endinterface

>>> rtl/free_page_stack_allocator.sv
// Free page stack allocator: LIFO free list of page frames in a link memory.
//
// The block keeps free pages as a singly linked LIFO list: a head register
// plus a link memory with one entry per page holding the next free page, with
// the value NUM_PAGES marking the end of the list. A free request pushes its
// page onto the list (pages at or above NUM_PAGES are ignored) and the free
// count saturates at NUM_PAGES. An allocate request takes the head page when
// it is at or below the limit; this needs one read of the link memory. When
// the head page is above the limit, the list is walked one link per cycle
// through the single read port of the link memory until the first page at or
// below the limit is found and unlinked, or until the walk reaches the end
// of the list or gives up after NUM_PAGES links. An empty list answers at
// once. Every request produces exactly one result; the result register
// lets a new request enter in the cycle the previous result is taken. The
// link memory has no reset and needs no clearing pass: only entries of
// pages that were freed are ever read. Double frees are not detected; the
// walk bound keeps the block from hanging on the loops they can create.
module free_page_stack_allocator #(
  parameter int NUM_PAGES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  fpsa_in_if.sink          in_if,
  fpsa_out_if.source       out_if
);
  import fpsa_pkg::*;

  // Index width of the memory, and width of a link that can also hold the
  // end-of-list marker NUM_PAGES.
  localparam int AW   = $clog2(NUM_PAGES);
  localparam int LW   = $clog2(NUM_PAGES + 1);
  localparam int CMPW = (LW > PAGE_W) ? LW : PAGE_W;

  localparam logic [LW-1:0] END_MARK = LW'(NUM_PAGES);
  localparam logic [LW-1:0] LAST_STEP = LW'(NUM_PAGES - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_POP    = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_UNLINK = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [LW-1:0] head_r, head_nxt;
  logic [LW-1:0] count_r, count_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  page_t         limit_r, limit_nxt;

  logic          out_valid_r, out_valid_nxt;
  page_t         out_page_r, out_page_nxt;
  logic          out_granted_r, out_granted_nxt;
  count_t        out_count_r, out_count_nxt;

  // Link memory: one write port, one read port with registered data.
  logic [LW-1:0] link_mem [NUM_PAGES];
  logic [LW-1:0] rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [LW-1:0] wr_data;

  logic          in_fire;
  logic          out_free;
  logic          head_ok;
  logic          cur_end;
  logic          cur_ok;
  logic [LW-1:0] count_dec;

  // The result register is free when empty or being drained this cycle.
  assign out_free  = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_if.valid && in_if.ready;

  assign head_ok   = CMPW'(head_r) <= CMPW'(in_if.limit_page);
  assign cur_end   = rd_data_r >= END_MARK;
  assign cur_ok    = CMPW'(rd_data_r) <= CMPW'(limit_r);
  assign count_dec = (count_r != '0) ? count_r - LW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    prev_nxt        = prev_r;
    cur_nxt         = cur_r;
    steps_nxt       = steps_r;
    limit_nxt       = limit_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_page_nxt    = out_page_r;
    out_granted_nxt = out_granted_r;
    out_count_nxt   = out_count_r;
    rd_en           = 1'b0;
    rd_addr         = AW'(head_r);
    wr_en           = 1'b0;
    wr_addr         = prev_r;
    wr_data         = rd_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          limit_nxt = in_if.limit_page;
          if (in_if.command == CMD_FREE) begin
            // Push: link the freed page to the old head.
            if (CMPW'(in_if.freed_page) < CMPW'(NUM_PAGES)) begin
              wr_en    = 1'b1;
              wr_addr  = AW'(in_if.freed_page);
              wr_data  = head_r;
              head_nxt = LW'(in_if.freed_page);
              if (count_r < END_MARK) begin
                count_nxt = count_r + LW'(1);
              end
            end
            out_valid_nxt   = 1'b1;
            out_page_nxt    = '0;
            out_granted_nxt = 1'b0;
            out_count_nxt   = COUNT_W'(count_nxt);
          end else if (head_r >= END_MARK) begin
            // Empty list.
            out_valid_nxt   = 1'b1;
            out_page_nxt    = '0;
            out_granted_nxt = 1'b0;
            out_count_nxt   = COUNT_W'(count_r);
          end else begin
            // Fetch the link of the head for either a pop or a walk.
            rd_en     = 1'b1;
            prev_nxt  = AW'(head_r);
            steps_nxt = '0;
            state_nxt = head_ok ? ST_POP : ST_WALK;
          end
        end
      end

      ST_POP: begin
        head_nxt        = rd_data_r;
        count_nxt       = count_dec;
        out_valid_nxt   = 1'b1;
        out_page_nxt    = PAGE_W'(prev_r);
        out_granted_nxt = 1'b1;
        out_count_nxt   = COUNT_W'(count_dec);
        state_nxt       = ST_IDLE;
      end

      ST_WALK: begin
        // rd_data_r holds the page that follows prev_r.
        if (cur_end || (!cur_ok && steps_r == LAST_STEP)) begin
          out_valid_nxt   = 1'b1;
          out_page_nxt    = '0;
          out_granted_nxt = 1'b0;
          out_count_nxt   = COUNT_W'(count_r);
          state_nxt       = ST_IDLE;
        end else if (cur_ok) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(rd_data_r);
          cur_nxt   = AW'(rd_data_r);
          state_nxt = ST_UNLINK;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(rd_data_r);
          prev_nxt  = AW'(rd_data_r);
          steps_nxt = steps_r + LW'(1);
        end
      end

      ST_UNLINK: begin
        // Bypass the matched page: prev now links to its successor.
        wr_en           = 1'b1;
        wr_addr         = prev_r;
        wr_data         = rd_data_r;
        count_nxt       = count_dec;
        out_valid_nxt   = 1'b1;
        out_page_nxt    = PAGE_W'(cur_r);
        out_granted_nxt = 1'b1;
        out_count_nxt   = COUNT_W'(count_dec);
        state_nxt       = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= END_MARK;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r        <= prev_nxt;
    cur_r         <= cur_nxt;
    steps_r       <= steps_nxt;
    limit_r       <= limit_nxt;
    out_page_r    <= out_page_nxt;
    out_granted_r <= out_granted_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.granted_page = out_page_r;
  assign out_if.granted      = out_granted_r;
  assign out_if.free_count   = out_count_r;

  // The count never passes the number of pages, and the head is a page or
  // the end marker.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= END_MARK)
    else $error("free count above page total");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= END_MARK)
    else $error("list head out of range");

  // A refused allocation or a free always reports page zero.
  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.granted) |-> (out_if.granted_page == '0))
    else $error("page reported without a grant");

  // A pop or an unlink is followed directly by idle with a granted result.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP || state_r == ST_UNLINK) |=>
      (state_r == ST_IDLE && out_valid_r && out_granted_r))
    else $error("allocation did not complete with a grant");

  // The walk stays within its bound.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (steps_r <= LAST_STEP))
    else $error("list walk exceeded its bound");

endmodule
